[hdl/tks_pkg.sv]
// Package for the top-k score table: record type, command codes, default ROM.
`timescale 1ns / 1ps
package tks_pkg;

    localparam int ENTRIES_DEF = 14;
    localparam int ROM_LEN     = 14;

    localparam logic [1:0] CMD_SUBMIT = 2'd0;
    localparam logic [1:0] CMD_READ   = 2'd1;
    localparam logic [1:0] CMD_RELOAD = 2'd2;

    typedef struct packed {
        logic [23:0] tag;
        logic [23:0] score;
        logic [15:0] lines;
        logic [7:0]  level;
    } t_rec;

    localparam int REC_W = $bits(t_rec);

    // Default record at rank r of table t; ranks past the ROM read as zero.
    function automatic t_rec rom_rec(input logic t, input int unsigned r);
        t_rec v;
        v = '0;
        if (r < ROM_LEN) begin
            if (!t) begin
                unique case (r)
                    0:  v = '{24'h415247, 24'd5470, 16'd143, 8'd22};
                    1:  v = '{24'h242424, 24'd4660, 16'd105, 8'd16};
                    2:  v = '{24'h414D44, 24'd4300, 16'd169, 8'd26};
                    3:  v = '{24'h455252, 24'd2630, 16'd30,  8'd5};
                    4:  v = '{24'h435055, 24'd2480, 16'd105, 8'd17};
                    5:  v = '{24'h575757, 24'd2360, 16'd72,  8'd12};
                    6:  v = '{24'h435143, 24'd1670, 16'd83,  8'd13};
                    7:  v = '{24'h414821, 24'd850,  16'd16,  8'd3};
                    8:  v = '{24'h59324B, 24'd620,  16'd33,  8'd5};
                    9:  v = '{24'h4F4A4F, 24'd360,  16'd24,  8'd4};
                    10: v = '{24'h604927, 24'd190,  16'd13,  8'd2};
                    11: v = '{24'h434F4D, 24'd90,   16'd6,   8'd1};
                    12: v = '{24'h323836, 24'd80,   16'd3,   8'd0};
                    default: v = '{24'h232140, 24'd10, 16'd0, 8'd0};
                endcase
            end else begin
                unique case (r)
                    0:  v = '{24'h415247, 24'd9670, 16'd190, 8'd29};
                    1:  v = '{24'h242424, 24'd2320, 16'd52,  8'd8};
                    2:  v = '{24'h414D44, 24'd1870, 16'd39,  8'd7};
                    3:  v = '{24'h455252, 24'd1540, 16'd30,  8'd6};
                    4:  v = '{24'h435055, 24'd1530, 16'd25,  8'd5};
                    5:  v = '{24'h575757, 24'd1410, 16'd28,  8'd7};
                    6:  v = '{24'h435143, 24'd1380, 16'd18,  8'd3};
                    7:  v = '{24'h414821, 24'd810,  16'd20,  8'd4};
                    8:  v = '{24'h59324B, 24'd720,  16'd17,  8'd3};
                    9:  v = '{24'h4F4A4F, 24'd670,  16'd11,  8'd3};
                    10: v = '{24'h604927, 24'd650,  16'd15,  8'd3};
                    11: v = '{24'h434F4D, 24'd530,  16'd14,  8'd3};
                    12: v = '{24'h323836, 24'd520,  16'd13,  8'd3};
                    default: v = '{24'h232140, 24'd320, 16'd8, 8'd4};
                endcase
            end
        end
        return v;
    endfunction

endpackage

[hdl/tks_if.sv]
// Request and response channel interfaces of the top-k score table.
`timescale 1ns / 1ps
interface tks_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic        table_select;
    logic        check_duplicate;
    logic [3:0]  read_index;
    logic [23:0] entry_tag;
    logic [23:0] entry_score;
    logic [15:0] entry_lines;
    logic [7:0]  entry_level;

    modport source (output valid, cmd, table_select, check_duplicate, read_index,
                    entry_tag, entry_score, entry_lines, entry_level, input ready);
    modport sink (input valid, cmd, table_select, check_duplicate, read_index,
                  entry_tag, entry_score, entry_lines, entry_level, output ready);
endinterface

interface tks_rsp_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic        was_present;
    logic [3:0]  placed_rank;
    logic [23:0] out_tag;
    logic [23:0] out_score;
    logic [15:0] out_lines;
    logic [7:0]  out_level;

    modport source (output valid, accepted, was_present, placed_rank, out_tag,
                    out_score, out_lines, out_level, input ready);
    modport sink (input valid, accepted, was_present, placed_rank, out_tag,
                  out_score, out_lines, out_level, output ready);
endinterface

[hdl/top_k_score_table.sv]
// Top level of the top-k score table: sequencer around one record RAM.
//
//  channel  | dir | handshake     | payload
//  i_req    | in  | valid / ready | cmd, table_select, check_duplicate, read_index, entry_*
//  o_rsp    | out | valid / ready | accepted, was_present, placed_rank, out_*
//
// Submit: one RAM read per rank to scan, then one read and write per rank from
// the insert rank down, then the response is posted. Read does one RAM read;
// reload rewrites the selected table from the ROM. All share the single RAM port pair.
// After reset a loading pass fills both tables from the default ROM; no
// transaction is accepted meanwhile. A stalled response holds in its register.
`timescale 1ns / 1ps
module top_k_score_table #(
    parameter int ENTRIES = tks_pkg::ENTRIES_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    tks_req_if.sink   i_req,
    tks_rsp_if.source o_rsp
);
    import tks_pkg::*;

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int AW = $clog2(2 * ENTRIES);

    typedef enum logic [6:0] {
        S_INIT  = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_SCAN  = 7'b0000100,
        S_SHIFT = 7'b0001000,
        S_READ  = 7'b0010000,
        S_LOAD  = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state        r_state;
    logic          r_t;
    logic          r_chk;
    logic [3:0]    r_ridx;
    t_rec          r_rec;
    t_rec          r_carry;
    logic [CW-1:0] r_cnt;
    logic          r_dv;
    logic [IW-1:0] r_dv_idx;
    logic          r_present;
    logic          r_found;
    logic [IW-1:0] r_pos;
    logic          r_res_acc;
    logic          r_res_pres;
    logic [3:0]    r_res_rank;
    t_rec          r_res_rec;
    logic          r_ov;
    logic          r_o_acc;
    logic          r_o_pres;
    logic [3:0]    r_o_rank;
    t_rec          r_o_rec;

    logic          we;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;
    t_rec          wdata;
    logic [REC_W-1:0] rdata;
    t_rec          rd_rec;
    logic          cnt_ok;
    logic          ridx_ok;
    logic          last;
    logic          n_present;
    logic          hit;
    logic [IW-1:0] ridx_cut;

    function automatic logic [AW-1:0] addr_of(input logic t, input logic [IW-1:0] idx);
        return (t ? AW'(ENTRIES) : AW'(0)) + AW'(idx);
    endfunction

    assign rd_rec    = t_rec'(rdata);
    assign cnt_ok    = r_cnt < CW'(ENTRIES);
    assign ridx_ok   = 32'(r_ridx) < ENTRIES;
    assign ridx_cut  = ridx_ok ? IW'(r_ridx) : '0;
    assign last      = r_dv && (r_dv_idx == IW'(ENTRIES - 1));
    assign n_present = r_present | (r_dv && (rd_rec == r_rec));
    assign hit       = r_dv && !r_found && (rd_rec.score < r_rec.score);

    // RAM address and write steering
    always_comb begin
        we    = 1'b0;
        waddr = addr_of(r_t, r_cnt[IW-1:0]);
        wdata = rom_rec(r_t, 32'(r_cnt));
        raddr = '0;
        unique case (r_state)
            S_SCAN: begin
                raddr = cnt_ok ? addr_of(r_t, r_cnt[IW-1:0]) : '0;
            end
            S_SHIFT: begin
                raddr = cnt_ok ? addr_of(r_t, r_cnt[IW-1:0]) : '0;
                we    = r_dv;
                waddr = addr_of(r_t, r_dv_idx);
                wdata = r_carry;
            end
            S_READ: begin
                raddr = addr_of(r_t, ridx_cut);
            end
            S_INIT, S_LOAD: begin
                we = 1'b1;
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    tks_ram #(.WIDTH(REC_W), .DEPTH(2 * ENTRIES)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign i_req.ready = (r_state == S_IDLE);

    // Sequence commands through the RAM
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_t     <= 1'b0;
            r_cnt   <= '0;
            r_dv    <= 1'b0;
        end else begin
            unique case (r_state)
                S_INIT, S_LOAD: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt[IW-1:0] == IW'(ENTRIES - 1)) begin
                        r_cnt <= '0;
                        if (r_state == S_INIT && !r_t) begin
                            r_t <= 1'b1;
                        end else begin
                            r_state <= (r_state == S_INIT) ? S_IDLE : S_DONE;
                        end
                    end
                end
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_t        <= i_req.table_select;
                        r_chk      <= i_req.check_duplicate;
                        r_ridx     <= i_req.read_index;
                        r_rec      <= '{i_req.entry_tag, i_req.entry_score,
                                        i_req.entry_lines, i_req.entry_level};
                        r_cnt      <= '0;
                        r_dv       <= 1'b0;
                        r_present  <= 1'b0;
                        r_found    <= 1'b0;
                        r_res_acc  <= 1'b0;
                        r_res_pres <= 1'b0;
                        r_res_rank <= 4'(ENTRIES);
                        r_res_rec  <= '0;
                        unique case (i_req.cmd)
                            CMD_SUBMIT: r_state <= S_SCAN;
                            CMD_READ:   r_state <= S_READ;
                            CMD_RELOAD: r_state <= S_LOAD;
                            default:    r_state <= S_DONE;
                        endcase
                    end
                end
                S_SCAN: begin
                    if (cnt_ok) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                    r_dv      <= cnt_ok;
                    r_dv_idx  <= r_cnt[IW-1:0];
                    r_present <= n_present;
                    if (hit) begin
                        r_found <= 1'b1;
                        r_pos   <= r_dv_idx;
                    end
                    if (last) begin
                        r_res_pres <= n_present;
                        if ((r_found || hit) && !(n_present && r_chk)) begin
                            r_res_acc  <= 1'b1;
                            r_res_rank <= 4'(hit ? r_dv_idx : r_pos);
                            r_cnt      <= CW'(hit ? r_dv_idx : r_pos);
                            r_carry    <= r_rec;
                            r_dv       <= 1'b0;
                            r_state    <= S_SHIFT;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_SHIFT: begin
                    // Write the carried record, pick up the displaced one
                    if (cnt_ok) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                    r_dv     <= cnt_ok;
                    r_dv_idx <= r_cnt[IW-1:0];
                    if (r_dv) begin
                        r_carry <= rd_rec;
                    end
                    if (last) begin
                        r_state <= S_DONE;
                    end
                end
                S_READ: begin
                    r_dv <= 1'b1;
                    if (r_dv) begin
                        r_dv <= 1'b0;
                        if (ridx_ok) begin
                            r_res_rec <= rd_rec;
                        end
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_ov || o_rsp.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Hold the response until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (r_state == S_DONE && (!r_ov || o_rsp.ready)) begin
            r_ov     <= 1'b1;
            r_o_acc  <= r_res_acc;
            r_o_pres <= r_res_pres;
            r_o_rank <= r_res_rank;
            r_o_rec  <= r_res_rec;
        end else if (o_rsp.ready) begin
            r_ov <= 1'b0;
        end
    end

    assign o_rsp.valid       = r_ov;
    assign o_rsp.accepted    = r_o_acc;
    assign o_rsp.was_present = r_o_pres;
    assign o_rsp.placed_rank = r_o_rank;
    assign o_rsp.out_tag     = r_o_rec.tag;
    assign o_rsp.out_score   = r_o_rec.score;
    assign o_rsp.out_lines   = r_o_rec.lines;
    assign o_rsp.out_level   = r_o_rec.level;

`ifndef SYNTH
    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_DONE) |-> !we)
        else $error("table written outside a command");
    a_shift_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == S_SHIFT) |-> $past(r_state == S_SCAN))
        else $error("shift pass entered without a scan");
    a_accept_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.accepted) |-> (o_rsp.out_tag == 24'd0 &&
        o_rsp.out_score == 24'd0))
        else $error("insert response carries read data");
`endif
endmodule

[hdl/tks_ram.sv]
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module tks_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
